### rtl/swsh_pkg.sv
// swsh_pkg: constants, the front-to-back command type and the hash helpers
// shared by the sampled window signature hash unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swsh_pkg;

    localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
    localparam logic [63:0] ROT_SEED   = 64'h9e3779b97f4a7c15;
    localparam logic [5:0]  ROT_LAST   = 6'd62;   // last rotate amount before wrap (mod 63)
    localparam logic [6:0]  SHIFT_MOD  = 7'd61;
    localparam logic [6:0]  SHIFT_STEP = 7'd7;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    typedef struct packed {
        logic        fold;   // fold hash into the accumulators
        logic        emit;   // produce a signature
        logic        whole;  // whole-file mode: hash goes out in both halves
        logic [63:0] hash;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = 128;

    // one FNV-1a step; prime 2^40 + 0x1b3 as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    // rotate left; an amount of zero leaves the value as it is
    function automatic logic [63:0] rot_left(input logic [63:0] v, input logic [5:0] r);
        logic [127:0] d;
        d = {v, v} << r;
        return d[127:64];
    endfunction

endpackage

`default_nettype wire

### rtl/sampled_window_signature_hash_unit.sv
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------------------
// input     | push / full        | data_byte, byte_valid, window_end, file_end,
//           |                    | small_file
// result    | empty / pop        | sig_lo, sig_hi
//
// One input transfer per cycle while full is low; the FNV-1a step (constant prime
// as shifts and adds) is combinational in the front. Window folds run in the back
// at one per cycle out of a CMD_DEPTH command queue unless a signature ahead of
// them waits for room; a signature passes from its file_end transfer through the
// command queue into the result queue. Reset empties both queues and sets the hash
// and the accumulators to their start values at once. full rises only while the
// command queue is full, which happens only when a signature has waited on a full result side.
// Depends on swsh_pkg, swsh_front, swsh_fifo and swsh_back.
`timescale 1ns / 1ps
`default_nettype none

module sampled_window_signature_hash_unit #(
    parameter int CMD_DEPTH = swsh_pkg::CMD_DEPTH,
    parameter int RES_DEPTH = swsh_pkg::RES_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        window_end,
    input  wire logic        file_end,
    input  wire logic        small_file,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      sig_lo,
    output logic [63:0]      sig_hi
);

    import swsh_pkg::*;

    cmd_t             cmd_in, cmd_out;
    logic [CMD_W-1:0] cmd_out_bits;
    logic             cmd_push, cmd_pop, cmd_full, cmd_empty;

    swsh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .window_end (window_end),
        .file_end   (file_end),
        .small_file (small_file),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    swsh_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out_bits),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_out_bits);

    swsh_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .sig_lo    (sig_lo),
        .sig_hi    (sig_hi)
    );

    // a command is never written into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !cmd_full)
        else $error("command written while queue full");

    // the back only takes commands that are there
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> !cmd_empty)
        else $error("command taken from empty queue");

    // a file end transfer always leaves a command behind for the back
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && file_end) |=> !cmd_empty)
        else $error("file end transfer lost");

    // no window fold command is made in whole-file mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd_in.whole) |-> !cmd_in.fold)
        else $error("fold command in whole-file mode");

endmodule

`default_nettype wire

### rtl/swsh_fifo.sv
// swsh_fifo: small first-in first-out register queue with count-based flags.
// Used between front and back and for the result side. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swsh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/swsh_front.sv
// swsh_front: takes input transfers, runs the per-window FNV-1a hash and
// turns window ends (outside whole-file mode) and file ends into commands for the back. Uses swsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swsh_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    data_byte,
    input  wire logic          byte_valid,
    input  wire logic          window_end,
    input  wire logic          file_end,
    input  wire logic          small_file,
    input  wire logic          cmd_full,
    output logic               cmd_push,
    output swsh_pkg::cmd_t     cmd
);

    import swsh_pkg::*;

    logic [63:0] hash_reg, hash_next;
    logic [63:0] hash_cur;
    logic        accept;
    logic        fold;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign fold   = window_end && !small_file;

    assign hash_cur = byte_valid ? fnv_step(hash_reg, data_byte) : hash_reg;

    assign cmd_push   = accept && (fold || file_end);
    assign cmd.fold   = fold;
    assign cmd.emit   = file_end;
    assign cmd.whole  = small_file;
    assign cmd.hash   = hash_cur;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = (fold || file_end) ? FNV_BASIS : hash_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

### rtl/swsh_back.sv
// swsh_back: folds window hashes into the xor and rotated-sum accumulators
// and queues finished signatures. Uses swsh_pkg and swsh_fifo.
`timescale 1ns / 1ps
`default_nettype none

module swsh_back #(
    parameter int RES_DEPTH = swsh_pkg::RES_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire swsh_pkg::cmd_t cmd,
    input  wire logic          cmd_empty,
    output logic               cmd_pop,
    input  wire logic          pop,
    output logic               empty,
    output logic [63:0]        sig_lo,
    output logic [63:0]        sig_hi
);

    import swsh_pkg::*;

    logic [63:0] xor_reg, xor_next;
    logic [63:0] rot_reg, rot_next;
    logic [5:0]  rot_amt_reg, rot_amt_next;
    logic [5:0]  shift_amt_reg, shift_amt_next;
    logic [63:0] xor_fold, rot_fold;
    logic [6:0]  shift_sum;
    logic [63:0] res_lo, res_hi;
    logic        res_full, res_push;
    logic [RES_W-1:0] res_data;

    // a signature waits for room on the result side; folds never stall
    assign cmd_pop  = !cmd_empty && (!cmd.emit || !res_full);
    assign res_push = cmd_pop && cmd.emit;

    assign xor_fold  = xor_reg ^ cmd.hash;
    assign rot_fold  = (rot_reg + rot_left(cmd.hash, rot_amt_reg)) ^ (cmd.hash >> shift_amt_reg);
    assign shift_sum = {1'b0, shift_amt_reg} + SHIFT_STEP;

    always_comb
    begin
        res_lo = cmd.fold ? xor_fold : xor_reg;
        res_hi = cmd.fold ? rot_fold : rot_reg;
        if (cmd.whole)
        begin
            res_lo = cmd.hash;
            res_hi = cmd.hash;
        end
    end

    assign res_data = {res_hi, res_lo};

    always_comb
    begin
        xor_next       = xor_reg;
        rot_next       = rot_reg;
        rot_amt_next   = rot_amt_reg;
        shift_amt_next = shift_amt_reg;
        if (cmd_pop)
        begin
            if (cmd.emit)
            begin
                xor_next       = '0;
                rot_next       = ROT_SEED;
                rot_amt_next   = '0;
                shift_amt_next = '0;
            end
            else if (cmd.fold)
            begin
                xor_next       = xor_fold;
                rot_next       = rot_fold;
                rot_amt_next   = (rot_amt_reg == ROT_LAST) ? '0 : rot_amt_reg + 1'b1;
                shift_amt_next = (shift_sum >= SHIFT_MOD) ? 6'(shift_sum - SHIFT_MOD)
                                                          : shift_sum[5:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg       <= '0;
            rot_reg       <= ROT_SEED;
            rot_amt_reg   <= '0;
            shift_amt_reg <= '0;
        end
        else
        begin
            xor_reg       <= xor_next;
            rot_reg       <= rot_next;
            rot_amt_reg   <= rot_amt_next;
            shift_amt_reg <= shift_amt_next;
        end
    end

    logic [RES_W-1:0] res_out;

    swsh_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign sig_lo = res_out[63:0];
    assign sig_hi = res_out[127:64];

endmodule

`default_nettype wire

### test/tb_sampled_window_signature_hash_unit.sv
// testbench for sampled_window_signature_hash_unit: directed table, then random files
// checked against a local window hash predictor. Depends on swsh_pkg and the unit.
`timescale 1ns / 1ps

module tb_sampled_window_signature_hash_unit;

    import swsh_pkg::FNV_BASIS;
    import swsh_pkg::ROT_SEED;

    localparam logic [63:0] HASH_MULT  = 64'h0000_0100_0000_01b3;
    localparam int          N_DIRECTED = 18;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } sig_pair_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        v;
        logic        we;
        logic        fe;
        logic        sm;
        logic        typed;   // signature below is taken as is, not predicted
        logic [63:0] lo;
        logic [63:0] hi;
    } stim_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'd0;
    logic        byte_valid = 1'b0;
    logic        window_end = 1'b0;
    logic        file_end = 1'b0;
    logic        small_file = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] sig_lo;
    logic [63:0] sig_hi;

    // predictor state
    logic [63:0] win_hash;
    logic [63:0] xor_acc;
    logic [63:0] rot_acc;
    logic [5:0]  rot_amt;
    logic [5:0]  shift_amt;

    sig_pair_t   expected_sigs[$];
    sig_pair_t   oldest_sig;
    stim_row_t   dir_rows[N_DIRECTED];
    int          errors = 0;
    int          items_sent = 0;
    int          files_sent = 0;
    int          send_idle = 0;
    int          recv_stall = 0;

    sampled_window_signature_hash_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .window_end (window_end),
        .file_end   (file_end),
        .small_file (small_file),
        .empty      (empty),
        .pop        (pop),
        .sig_lo     (sig_lo),
        .sig_hi     (sig_hi)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
        if (r == 6'd0)
            return v;
        return (v << r) | (v >> (7'd64 - {1'b0, r}));
    endfunction

    task automatic clear_hash_state();
        win_hash  = FNV_BASIS;
        xor_acc   = 64'd0;
        rot_acc   = ROT_SEED;
        rot_amt   = 6'd0;
        shift_amt = 6'd0;
    endtask

    task automatic predict_signature(input stim_row_t row, output bit emits,
                                     output sig_pair_t sig);
        logic [63:0] w;
        emits = 1'b0;
        sig   = '0;
        if (row.v)
            win_hash = (win_hash ^ {56'd0, row.b}) * HASH_MULT;
        // window close is ignored in whole-file mode
        if (row.we && !row.sm)
        begin
            w = win_hash;
            xor_acc = xor_acc ^ w;
            rot_acc = rot_acc + rotl64(w, rot_amt);
            rot_acc = rot_acc ^ (w >> shift_amt);
            rot_amt = (rot_amt == 6'd62) ? 6'd0 : rot_amt + 6'd1;
            shift_amt = 6'((int'(shift_amt) + 7) % 61);
            win_hash = FNV_BASIS;
        end
        if (row.fe)
        begin
            emits  = 1'b1;
            sig.lo = row.sm ? win_hash : xor_acc;
            sig.hi = row.sm ? win_hash : rot_acc;
            clear_hash_state();
        end
    endtask

    // drive one item and hold it until the transfer, then record what it should produce
    task automatic send_item(input stim_row_t row);
        bit        emits;
        sig_pair_t sig;
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        data_byte  <= row.b;
        byte_valid <= row.v;
        window_end <= row.we;
        file_end   <= row.fe;
        small_file <= row.sm;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        predict_signature(row, emits, sig);
        if (emits)
        begin
            files_sent++;
            if (row.typed)
            begin
                sig.lo = row.lo;
                sig.hi = row.hi;
            end
            expected_sigs.push_back(sig);
        end
    endtask

    task automatic send_file(input int n_win, input int max_bytes, input bit small_mode);
        stim_row_t row;
        int        nb;
        for (int w = 0; w < n_win; w++)
        begin
            nb = $urandom_range(max_bytes, 0);
            for (int k = 0; k < nb; k++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    row = '{8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, small_mode,
                            1'b0, 64'd0, 64'd0};
                    send_item(row);
                end
                row = '{8'($urandom_range(255)), 1'b1,
                        small_mode ? 1'($urandom_range(1)) : 1'b0, 1'b0,
                        small_mode ^ ($urandom_range(99) < 3), 1'b0, 64'd0, 64'd0};
                send_item(row);
            end
            // an odd item with the mode flag flipped mixes the two modes
            row = '{8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0,
                    small_mode ^ ($urandom_range(99) < 3), 1'b0, 64'd0, 64'd0};
            send_item(row);
        end
        row = '{8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'b1, small_mode, 1'b0, 64'd0, 64'd0};
        send_item(row);
    endtask

    // result side: check each transfer, then decide whether to stall
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_sigs.size() == 0)
                begin
                    $display("%0t: signature with none pending: lo=%h hi=%h",
                             $time, sig_lo, sig_hi);
                    errors++;
                end
                else
                begin
                    oldest_sig = expected_sigs.pop_front();
                    if (sig_lo !== oldest_sig.lo)
                    begin
                        $display("%0t: sig_lo expected %h, got %h", $time, oldest_sig.lo, sig_lo);
                        errors++;
                    end
                    if (sig_hi !== oldest_sig.hi)
                    begin
                        $display("%0t: sig_hi expected %h, got %h", $time, oldest_sig.hi, sig_hi);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        #4_000_000;
        $display("sampled_window_signature_hash_unit: mismatch");
        $finish;
    end

    initial
    begin
        int        phase_items;
        int        phase_files;
        bit        small_mode;
        clear_hash_state();
        dir_rows = '{
            '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 64'd0, ROT_SEED},     // no windows at all
            '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, FNV_BASIS, FNV_BASIS}, // whole file, no bytes
            '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0},
            '{8'hff, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0},
            '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0},       // empty window
            '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0},       // bare marker
            '{8'ha5, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0, 64'd0},
            '{8'hff, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 64'd0, 64'd0},
            '{8'h80, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 64'd0, 64'd0},       // close ignored
            '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0, 64'd0},
            '{8'h5a, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0},
            '{8'h3c, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0},
            '{8'h11, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0, 64'd0},       // open window dropped
            '{8'h12, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0},
            '{8'h34, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 64'd0, 64'd0},
            '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 64'd0, 64'd0},
            '{8'h01, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0, 64'd0},
            '{8'h7f, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0, 64'd0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(dir_rows[i]);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 73; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 73; end
                default: begin send_idle = 20; recv_stall = 20; end
            endcase
            if (p == 2)
            begin
                // hold off until the result side has drained
                push <= 1'b0;
                while (expected_sigs.size() != 0)
                    @(posedge clk);
            end
            phase_items = items_sent;
            phase_files = files_sent;
            // long files run the rotate and shift counters past their wrap
            if (p == 1)
                send_file(66, 1, 1'b0);
            else if (p == 3)
                send_file(70, 1, 1'b0);
            while (items_sent - phase_items < 100 || files_sent - phase_files < 8)
            begin
                small_mode = ($urandom_range(99) < 20);
                if (small_mode)
                    send_file(1, 8, 1'b1);
                else
                    send_file($urandom_range(5, 1), 3, 1'b0);
            end
        end
        push <= 1'b0;

        while (expected_sigs.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("sampled_window_signature_hash_unit: match");
        else
            $display("sampled_window_signature_hash_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
rtl/swsh_pkg.sv
rtl/swsh_fifo.sv
rtl/swsh_front.sv
rtl/swsh_back.sv
rtl/sampled_window_signature_hash_unit.sv
test/tb_sampled_window_signature_hash_unit.sv
